>>> src/xep_pkg.sv
// xep_pkg: shared types, codes, reset salt and the xorshift32 function
// for the xorshift entropy pool. No dependencies.
package xep_pkg;

   localparam int unsigned POOL_DEPTH = 8;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned BYTE_W     = 8;

   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_GET = 1'b1;

   localparam logic [2:0] CROSS_STEP = 3'd3;

   typedef logic [POOL_DEPTH-1:0][WORD_W-1:0] pool_type;

   typedef struct packed {
      logic              func;
      logic [WORD_W-1:0] sample;
      logic [WORD_W-1:0] byte_index;
   } req_type;

   // words 7..0
   localparam pool_type POOL_SALT = {
      32'h1234_5678, 32'h0000_0000, 32'hCAFE_BABE, 32'h0000_0000,
      32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
   };

   function automatic logic [WORD_W-1:0] shuffle32(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] v;
      v = x ^ (x << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

endpackage

>>> src/xorshift_entropy_pool.sv
// Xorshift entropy pool: eight 32-bit words, a rotating mix position and a
// stir counter; add beats mix a sample in, get beats return one random byte.
// Throughput is one beat per cycle, add or get, unless a get beat is stalled. A
// get beat's byte reaches rsp_random_byte through the input register and then
// the result register; the whole pool update (stir plus draw) is combinational
// from the input register into the result register, which is what lets the next
// beat see the new pool at once. While a result is held by rsp_stall, a get
// beat waits in the input register and stalls the input; add beats pass.
// Add beats produce no result. Depends on xep_pkg and xep_mix.
module xorshift_entropy_pool (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [xep_pkg::WORD_W-1:0]  req_sample,
   input  logic [xep_pkg::WORD_W-1:0]  req_byte_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [xep_pkg::BYTE_W-1:0]  rsp_random_byte
);

   logic                       s1_valid_ff;
   xep_pkg::req_type           s1_req_ff;
   xep_pkg::pool_type          pool_ff;
   logic [2:0]                 pos_ff;
   logic [xep_pkg::WORD_W-1:0] count_ff;
   logic                       rsp_valid_ff;
   logic [xep_pkg::BYTE_W-1:0] rsp_byte_ff;

   xep_pkg::pool_type          pool_in;
   logic [2:0]                 pos_in;
   logic [xep_pkg::WORD_W-1:0] count_in;
   logic [xep_pkg::BYTE_W-1:0] byte_in;
   logic                       s1_advance;
   logic                       req_take;

   assign s1_advance = s1_valid_ff &&
                       (s1_req_ff.func == xep_pkg::FUNC_ADD || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   xep_mix u_mix (
      .item        (s1_req_ff),
      .pool        (pool_ff),
      .pos         (pos_ff),
      .count       (count_ff),
      .pool_next   (pool_in),
      .pos_next    (pos_in),
      .count_next  (count_in),
      .random_byte (byte_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pool_ff      <= xep_pkg::POOL_SALT;
         pos_ff       <= 3'd0;
         count_ff     <= '0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            pool_ff  <= pool_in;
            pos_ff   <= pos_in;
            count_ff <= count_in;
         end
         if (s1_advance && s1_req_ff.func == xep_pkg::FUNC_GET) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff.func       <= req_func;
         s1_req_ff.sample     <= req_sample;
         s1_req_ff.byte_index <= req_byte_index;
      end
      if (s1_advance && s1_req_ff.func == xep_pkg::FUNC_GET) begin
         rsp_byte_ff <= byte_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_byte = rsp_byte_ff;

   a_add_steps_count: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_req_ff.func == xep_pkg::FUNC_ADD)
      |=> (count_ff == $past(count_ff) + 32'd1) && (pos_ff == $past(pos_ff) + 3'd1))
      else $error("add beat did not step counter and position");

   a_plain_get_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_req_ff.func == xep_pkg::FUNC_GET &&
       s1_req_ff.byte_index[1:0] != 2'b00)
      |=> $stable(count_ff) && $stable(pos_ff))
      else $error("non-stirring get changed counter or position");

   a_rsp_from_get: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_advance && s1_req_ff.func == xep_pkg::FUNC_GET))
      else $error("result beat without a get beat");

   a_stall_held_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule

>>> src/xep_mix.sv
// xep_mix: next-state logic of the pool for one item (optional stir, then
// the byte draw). Depends on xep_pkg.
module xep_mix (
   input  xep_pkg::req_type            item,
   input  xep_pkg::pool_type           pool,
   input  logic [2:0]                  pos,
   input  logic [xep_pkg::WORD_W-1:0]  count,
   output xep_pkg::pool_type           pool_next,
   output logic [2:0]                  pos_next,
   output logic [xep_pkg::WORD_W-1:0]  count_next,
   output logic [xep_pkg::BYTE_W-1:0]  random_byte
);

   always_comb begin
      logic                       stir;
      logic [2:0]                 p;
      logic [2:0]                 q;
      logic [2:0]                 a;
      logic [2:0]                 b;
      logic [xep_pkg::WORD_W-1:0] mixed;
      logic [xep_pkg::WORD_W-1:0] w;
      xep_pkg::pool_type          mid;
      stir  = (item.func == xep_pkg::FUNC_ADD) || (item.byte_index[1:0] == 2'b00);
      p     = pos + 3'd1;
      q     = p + xep_pkg::CROSS_STEP;
      mixed = xep_pkg::shuffle32((pool[p] ^ item.sample) + count);
      mid        = pool;
      pos_next   = pos;
      count_next = count;
      if (stir) begin
         mid[p]     = mixed;
         mid[q]     = pool[q] ^ mixed;
         pos_next   = p;
         count_next = count + 32'd1;
      end
      // byte draw
      a = item.byte_index[2:0];
      b = a + xep_pkg::CROSS_STEP;
      w = xep_pkg::shuffle32((mid[a] ^ mid[b]) + count_next + item.byte_index);
      pool_next = mid;
      if (item.func == xep_pkg::FUNC_GET) begin
         pool_next[a] = w;
      end
      random_byte = w[xep_pkg::BYTE_W-1:0];
   end

endmodule
